@@ design/mc3e_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mc3e_pkg: shared types and constants of the 3E request frame builder
// Holds the request kind codes, command words, register indexes and the job
// record that travels from the front end to the byte serializer.
// ----------------------------------------------------------------------------
package mc3e_pkg;

    // Action flag of an input item.
    localparam logic ACT_HEADER = 1'b0;
    localparam logic ACT_VALUE  = 1'b1;

    // Request kinds.
    localparam logic [1:0] KIND_READ_BITS   = 2'd0;
    localparam logic [1:0] KIND_WRITE_BITS  = 2'd1;
    localparam logic [1:0] KIND_READ_WORDS  = 2'd2;
    localparam logic [1:0] KIND_WRITE_WORDS = 2'd3;

    // Command and subcommand words.
    localparam logic [15:0] CMD_READ  = 16'h0401;
    localparam logic [15:0] CMD_WRITE = 16'h1401;
    localparam logic [15:0] SUB_BIT   = 16'h0001;
    localparam logic [15:0] SUB_WORD  = 16'h0000;

    // Device letters that turn a long bit read into a word read.
    localparam logic [7:0] LETTER_X = 8'h58;
    localparam logic [7:0] LETTER_Y = 8'h59;
    localparam logic [7:0] LETTER_M = 8'h4D;

    // Point count limit; larger counts saturate to it.
    localparam logic [10:0] MAX_POINTS = 11'd1024;

    // Fixed part of the request length (request length field counts
    // monitoring time onward: 2 bytes of timer plus 10 bytes of request).
    localparam logic [15:0] LEN_BASE = 16'd12;

    // Frame layout.
    localparam int HEADER_BYTES = 21;
    localparam int IDX_W        = 5;
    localparam logic [IDX_W-1:0] IDX_HEADER_END = IDX_W'(HEADER_BYTES - 1);
    localparam logic [IDX_W-1:0] IDX_WORD_END   = IDX_W'(1);
    localparam logic [IDX_W-1:0] IDX_BYTE_END   = IDX_W'(0);

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_SUB_HEADER     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NETWORK_NUMBER = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PC_NUMBER      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DEST_MODULE_IO = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STATION_NUMBER = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MONITOR_TIME   = 3'd5;

    // Kind of work the serializer carries out.
    typedef enum logic [1:0] {
        JOB_HEADER,
        JOB_WORD,
        JOB_BYTE
    } t_job_kind;

    // Configuration register set.
    typedef struct packed {
        logic [15:0] sub_header;
        logic [7:0]  network_number;
        logic [7:0]  pc_number;
        logic [15:0] dest_module_io;
        logic [7:0]  station_number;
        logic [15:0] monitor_time;
    } t_cfg;

    // One unit of work for the serializer.
    typedef struct packed {
        t_job_kind   kind;
        logic        is_write;
        logic        sub_word;
        logic [15:0] req_len;
        logic [23:0] start_address;
        logic [7:0]  dev_code;
        logic [10:0] count;
        logic [15:0] value;
        logic        last;
    } t_job;

    // Queue handshake between front end and serializer.
    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_stat;

endpackage

@@ design/mc3e_request_frame_builder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mc3e_request_frame_builder: 3E binary request frame builder
// Turns request headers and write values into the byte stream of a 3E
// binary request frame.
//
// Channel   Direction  Contents
// s_axis    in         tuser: action, request_kind; tdata: device_letter,
//                      dev_code, start_address, point_count, write_value
// m_axis    out        tdata: out_byte; tlast: frame_last
// cfg       in         register index and 16-bit write data, write only
//
// The output delivers one byte per cycle while the receiver keeps tready high: a
// header item makes 21 bytes, a word write value 2 and a bit write pair 1.
// The serializer in mc3e_back sets the sustained rate; the two-entry job
// queue lets the input take items while earlier bytes are still going out.
// Reset is synchronous and active low; it restores the register defaults and
// drops any open request.
// A stall on the output fills the job queue, after which input tready drops.
// ----------------------------------------------------------------------------
module mc3e_request_frame_builder
    import mc3e_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Item input.
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    // [7:0] device_letter, [15:8] dev_code, [39:16] start_address,
    // [50:40] point_count, [66:51] write_value, [71:67] zero
    input  logic [71:0]          i_s_axis_tdata,
    // [0] action, [2:1] request_kind
    input  logic [2:0]           i_s_axis_tuser,
    // Byte output.
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    // [7:0] out_byte
    output logic [7:0]           o_m_axis_tdata,
    // frame_last
    output logic                 o_m_axis_tlast,
    // Configuration write port.
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]          i_cfg_wdata
);

    t_cfg        r_cfg;
    t_job        w_job;
    t_job        w_head;
    t_queue_stat w_queue;
    logic        w_push;
    logic        w_pop;
    logic        w_in_accept;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sub_header     <= 16'h5000;
            r_cfg.network_number <= 8'h00;
            r_cfg.pc_number      <= 8'hFF;
            r_cfg.dest_module_io <= 16'h03FF;
            r_cfg.station_number <= 8'h00;
            r_cfg.monitor_time   <= 16'h0010;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                REG_SUB_HEADER:     r_cfg.sub_header     <= i_cfg_wdata;
                REG_NETWORK_NUMBER: r_cfg.network_number <= i_cfg_wdata[7:0];
                REG_PC_NUMBER:      r_cfg.pc_number      <= i_cfg_wdata[7:0];
                REG_DEST_MODULE_IO: r_cfg.dest_module_io <= i_cfg_wdata;
                REG_STATION_NUMBER: r_cfg.station_number <= i_cfg_wdata[7:0];
                REG_MONITOR_TIME:   r_cfg.monitor_time   <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Item classifier.
    mc3e_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_s_axis_tvalid),
        .o_ready         (o_s_axis_tready),
        .i_action        (i_s_axis_tuser[0]),
        .i_request_kind  (i_s_axis_tuser[2:1]),
        .i_device_letter (i_s_axis_tdata[7:0]),
        .i_dev_code      (i_s_axis_tdata[15:8]),
        .i_start_address (i_s_axis_tdata[39:16]),
        .i_point_count   (i_s_axis_tdata[50:40]),
        .i_write_value   (i_s_axis_tdata[66:51]),
        .i_queue         (w_queue),
        .o_push          (w_push),
        .o_job           (w_job)
    );

    // Job queue.
    mc3e_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_stat  (w_queue)
    );

    // Byte serializer.
    mc3e_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_head  (w_head),
        .i_queue (w_queue),
        .o_pop   (w_pop),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_byte  (o_m_axis_tdata),
        .o_last  (o_m_axis_tlast)
    );

    assign w_in_accept = i_s_axis_tvalid && o_s_axis_tready;

    // The classifier never writes into a full queue.
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_push && w_queue.full))
        else $error("job pushed into full queue");

    // The serializer never takes a job from an empty queue.
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_pop && w_queue.empty))
        else $error("job popped from empty queue");

    // Every accepted header item becomes a header job.
    a_header_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_accept && (i_s_axis_tuser[0] == ACT_HEADER)) |-> w_push)
        else $error("header item produced no job");

    // Reset leaves the queue empty.
    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> w_queue.empty)
        else $error("queue not empty after reset");

endmodule

@@ design/mc3e_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mc3e_front: item classifier of the 3E request frame builder
// Accepts header and write value items, tracks the open request and turns
// each item into at most one job for the serializer.
// ----------------------------------------------------------------------------
module mc3e_front
    import mc3e_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_action,
    input  logic [1:0]  i_request_kind,
    input  logic [7:0]  i_device_letter,
    input  logic [7:0]  i_dev_code,
    input  logic [23:0] i_start_address,
    input  logic [10:0] i_point_count,
    input  logic [15:0] i_write_value,
    input  t_queue_stat i_queue,
    output logic        o_push,
    output t_job        o_job
);

    logic [1:0]  r_active_kind, n_active_kind;
    logic [10:0] r_values_left, n_values_left;
    logic        r_held_bit, n_held_bit;
    logic        r_holding, n_holding;

    logic        w_accept;
    logic [10:0] w_points;
    logic        w_letter_hit;
    logic        w_word_bit_read;
    logic [11:0] w_words;
    logic [11:0] w_half;
    logic [15:0] w_payload;
    logic [10:0] w_left_dec;
    logic        w_bit;

    assign o_ready  = !i_queue.full;
    assign w_accept = i_valid && o_ready;

    // Header arithmetic: saturated count, word-read conversion, length.
    always_comb begin
        w_points        = (i_point_count > MAX_POINTS) ? MAX_POINTS : i_point_count;
        w_letter_hit    = (i_device_letter == LETTER_X) || (i_device_letter == LETTER_Y)
                          || (i_device_letter == LETTER_M);
        w_word_bit_read = (i_request_kind == KIND_READ_BITS) && (w_points > 11'd8)
                          && w_letter_hit;
        w_words         = (12'(w_points) + 12'd15) >> 4;
        w_half          = (12'(w_points) + 12'd1) >> 1;
        case (i_request_kind)
            KIND_WRITE_BITS:  w_payload = 16'(w_half);
            KIND_WRITE_WORDS: w_payload = {4'b0, w_points, 1'b0};
            default:          w_payload = 16'd0;
        endcase
        w_left_dec = r_values_left - 11'd1;
        w_bit      = i_write_value[0];
    end

    // Request tracking and job generation.
    always_comb begin
        n_active_kind = r_active_kind;
        n_values_left = r_values_left;
        n_held_bit    = r_held_bit;
        n_holding     = r_holding;
        o_push        = 1'b0;
        o_job         = '0;
        o_job.value   = i_write_value;

        if (w_accept) begin
            if (i_action == ACT_HEADER) begin
                n_active_kind       = i_request_kind;
                n_values_left       = i_request_kind[0] ? w_points : 11'd0;
                n_held_bit          = 1'b0;
                n_holding           = 1'b0;
                o_push              = 1'b1;
                o_job.kind          = JOB_HEADER;
                o_job.is_write      = i_request_kind[0];
                o_job.sub_word      = i_request_kind[1] || w_word_bit_read;
                o_job.req_len       = LEN_BASE + w_payload;
                o_job.start_address = i_start_address;
                o_job.dev_code      = i_dev_code;
                o_job.count         = w_word_bit_read ? 11'(w_words) : w_points;
                o_job.last          = !(i_request_kind[0] && (w_points != 11'd0));
            end else if (r_values_left != 11'd0) begin
                n_values_left = w_left_dec;
                if (r_active_kind == KIND_WRITE_WORDS) begin
                    o_push     = 1'b1;
                    o_job.kind = JOB_WORD;
                    o_job.last = (w_left_dec == 11'd0);
                end else if (r_active_kind != KIND_WRITE_BITS) begin
                    n_values_left = 11'd0;
                end else if (r_holding) begin
                    // Second point of a pair completes the byte.
                    n_holding   = 1'b0;
                    n_held_bit  = 1'b0;
                    o_push      = 1'b1;
                    o_job.kind  = JOB_BYTE;
                    o_job.value = {8'd0, 3'd0, r_held_bit, 3'd0, w_bit};
                    o_job.last  = (w_left_dec == 11'd0);
                end else if (w_left_dec == 11'd0) begin
                    // Odd count: the final point gets a byte of its own.
                    o_push      = 1'b1;
                    o_job.kind  = JOB_BYTE;
                    o_job.value = {8'd0, 3'd0, w_bit, 4'd0};
                    o_job.last  = 1'b1;
                end else begin
                    n_held_bit = w_bit;
                    n_holding  = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_kind <= KIND_READ_BITS;
            r_values_left <= 11'd0;
            r_held_bit    <= 1'b0;
            r_holding     <= 1'b0;
        end else begin
            r_active_kind <= n_active_kind;
            r_values_left <= n_values_left;
            r_held_bit    <= n_held_bit;
            r_holding     <= n_holding;
        end
    end

endmodule

@@ design/mc3e_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mc3e_queue: two-entry job queue
// Decouples the item classifier from the byte serializer so either side can
// stall without holding up the other until the queue runs full or empty.
// ----------------------------------------------------------------------------
module mc3e_queue
    import mc3e_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  t_job        i_job,
    input  logic        i_pop,
    output t_job        o_head,
    output t_queue_stat o_stat
);

    localparam int DEPTH = 2;

    t_job        r_mem [DEPTH];
    logic        r_wr_ptr, n_wr_ptr;
    logic        r_rd_ptr, n_rd_ptr;
    logic [1:0]  r_count, n_count;

    // Occupancy and pointer update.
    always_comb begin
        n_wr_ptr = i_push ? !r_wr_ptr : r_wr_ptr;
        n_rd_ptr = i_pop ? !r_rd_ptr : r_rd_ptr;
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + 2'd1;
            2'b01:   n_count = r_count - 2'd1;
            default: n_count = r_count;
        endcase
    end

    assign o_stat.full  = (r_count == 2'(DEPTH));
    assign o_stat.empty = (r_count == 2'd0);
    assign o_head       = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Job storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

@@ design/mc3e_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mc3e_back: byte serializer of the 3E request frame builder
// Walks the job at the head of the queue one byte per cycle, while the output
// is not stalled, into a registered output stage.
// ----------------------------------------------------------------------------
module mc3e_back
    import mc3e_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  t_job        i_head,
    input  t_queue_stat i_queue,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_byte,
    output logic        o_last
);

    logic [IDX_W-1:0] r_idx, n_idx;
    logic             r_out_valid, n_out_valid;
    logic [7:0]       r_out_byte;
    logic             r_out_last;

    logic             w_load;
    logic [7:0]       w_byte;
    logic             w_end;
    logic [15:0]      w_cmd;
    logic [15:0]      w_sub;

    assign w_load = !i_queue.empty && (!r_out_valid || i_ready);
    assign o_pop  = w_load && w_end;

    // Byte selection for the current position of the head job.
    always_comb begin
        w_cmd  = i_head.is_write ? CMD_WRITE : CMD_READ;
        w_sub  = i_head.sub_word ? SUB_WORD : SUB_BIT;
        w_byte = i_head.value[7:0];
        w_end  = 1'b1;
        case (i_head.kind)
            JOB_HEADER: begin
                w_end = (r_idx == IDX_HEADER_END);
                case (r_idx)
                    5'd0:    w_byte = i_cfg.sub_header[15:8];
                    5'd1:    w_byte = i_cfg.sub_header[7:0];
                    5'd2:    w_byte = i_cfg.network_number;
                    5'd3:    w_byte = i_cfg.pc_number;
                    5'd4:    w_byte = i_cfg.dest_module_io[7:0];
                    5'd5:    w_byte = i_cfg.dest_module_io[15:8];
                    5'd6:    w_byte = i_cfg.station_number;
                    5'd7:    w_byte = i_head.req_len[7:0];
                    5'd8:    w_byte = i_head.req_len[15:8];
                    5'd9:    w_byte = i_cfg.monitor_time[7:0];
                    5'd10:   w_byte = i_cfg.monitor_time[15:8];
                    5'd11:   w_byte = w_cmd[7:0];
                    5'd12:   w_byte = w_cmd[15:8];
                    5'd13:   w_byte = w_sub[7:0];
                    5'd14:   w_byte = w_sub[15:8];
                    5'd15:   w_byte = i_head.start_address[7:0];
                    5'd16:   w_byte = i_head.start_address[15:8];
                    5'd17:   w_byte = i_head.start_address[23:16];
                    5'd18:   w_byte = i_head.dev_code;
                    5'd19:   w_byte = i_head.count[7:0];
                    default: w_byte = {5'd0, i_head.count[10:8]};
                endcase
            end
            JOB_WORD: begin
                w_end  = (r_idx == IDX_WORD_END);
                w_byte = (r_idx == IDX_BYTE_END) ? i_head.value[7:0] : i_head.value[15:8];
            end
            default: begin
                w_end  = 1'b1;
                w_byte = i_head.value[7:0];
            end
        endcase
    end

    // Position counter and output stage control.
    always_comb begin
        n_idx       = r_idx;
        n_out_valid = r_out_valid;
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end
        if (w_load) begin
            n_out_valid = 1'b1;
            n_idx       = w_end ? '0 : r_idx + IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    // Output payload.
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_byte <= w_byte;
            r_out_last <= w_end && i_head.last;
        end
    end

    assign o_valid = r_out_valid;
    assign o_byte  = r_out_byte;
    assign o_last  = r_out_last;

endmodule

@@ tb/mc3e_request_frame_builder_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mc3e_request_frame_builder_tb: self-checking bench of the 3E frame builder
// Request headers and write values go in on the item stream. A local frame
// predictor works out every byte and its frame_last flag for each accepted
// item. The output bytes are checked in order against those predictions.
// A short directed pass covers field extremes, the word read of long bit
// reads on X, Y and M, odd bit counts, ignored values and abandoned frames.
// Random request sequences then run under several register settings and
// several sender and receiver pacing patterns.
// ----------------------------------------------------------------------------
module mc3e_request_frame_builder_tb;
    import mc3e_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int HOLD_CYCLES   = 400;
    localparam int DRAIN_CYCLES  = 40;
    localparam int PRINT_LIMIT   = 40;
    localparam int PHASE_ITEMS   = 13;
    localparam int DIR_ROWS      = 25;
    localparam logic [7:0] LETTER_LOWER_X = 8'h78;
    localparam logic [7:0] LETTER_D       = 8'h44;

    // Register values after reset.
    localparam t_cfg CFG_RESET = '{16'h5000, 8'h00, 8'hFF, 16'h03FF, 8'h00, 16'h0010};

    // Pacing of the two stream sides.
    typedef enum logic [1:0] {
        PACE_NONE,
        PACE_SRC,
        PACE_SINK,
        PACE_BOTH
    } t_pace;

    // One input item, field by field.
    typedef struct packed {
        logic        action;
        logic [1:0]  kind;
        logic [7:0]  letter;
        logic [7:0]  code;
        logic [23:0] addr;
        logic [10:0] count;
        logic [15:0] value;
    } t_req_item;

    // One output byte of the frame.
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_frame_byte;

    // Directed row: item plus, where obvious, the byte count it causes and
    // the last of those bytes.
    typedef struct packed {
        logic        action;
        logic [1:0]  kind;
        logic [7:0]  letter;
        logic [7:0]  code;
        logic [23:0] addr;
        logic [10:0] count;
        logic [15:0] value;
        logic        chk;
        logic [4:0]  exp_n;
        logic [7:0]  exp_tail;
        logic        exp_last;
    } t_dir_row;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_s_axis_tvalid = 1'b0;
    logic         o_s_axis_tready;
    logic [71:0]  i_s_axis_tdata = '0;
    logic [2:0]   i_s_axis_tuser = '0;
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready = 1'b0;
    logic [7:0]   o_m_axis_tdata;
    logic         o_m_axis_tlast;
    logic         i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [15:0]  i_cfg_wdata = '0;

    // Predictor state.
    t_cfg        cfg_model = CFG_RESET;
    logic [1:0]  open_kind = '0;
    logic [10:0] values_due = '0;
    logic        held_pt = 1'b0;
    logic        pair_open = 1'b0;

    // Expected bytes, oldest first, and what the latest item produced.
    t_frame_byte pending_bytes[$];
    int          made_n;
    t_frame_byte made_tail;

    int   error_count = 0;
    int   items_taken = 0;
    int   cycle_count = 0;
    int   src_idle_pct = 0;
    int   sink_stall_pct = 0;
    bit   hold_request = 1'b0;

    t_dir_row directed_rows [0:DIR_ROWS-1] = '{
        // Read bits, all fields zero but the letter: bit access, count 0.
        '{ACT_HEADER, KIND_READ_BITS, LETTER_X, 8'h00, 24'h000000, 11'd0, 16'h0000,
          1'b1, 5'd21, 8'h00, 1'b1},
        // Read words, all fields at their top: count saturates to 1024.
        '{ACT_HEADER, KIND_READ_WORDS, 8'hFF, 8'hFF, 24'hFFFFFF, 11'd2047, 16'hFFFF,
          1'b1, 5'd21, 8'h04, 1'b1},
        // Long bit reads on X, Y and M turn into word reads.
        '{ACT_HEADER, KIND_READ_BITS, LETTER_X, 8'h9C, 24'h000010, 11'd9, 16'h0000,
          1'b0, 5'd0, 8'h00, 1'b0},
        '{ACT_HEADER, KIND_READ_BITS, LETTER_Y, 8'h9D, 24'h123456, 11'd1024, 16'h0000,
          1'b0, 5'd0, 8'h00, 1'b0},
        '{ACT_HEADER, KIND_READ_BITS, LETTER_M, 8'h90, 24'h00FF00, 11'd17, 16'h0000,
          1'b0, 5'd0, 8'h00, 1'b0},
        // Lower-case letter and a count of 8 stay bit reads.
        '{ACT_HEADER, KIND_READ_BITS, LETTER_LOWER_X, 8'h9C, 24'h000001, 11'd100, 16'h0000,
          1'b0, 5'd0, 8'h00, 1'b0},
        '{ACT_HEADER, KIND_READ_BITS, LETTER_X, 8'h9C, 24'h000002, 11'd8, 16'h0000,
          1'b0, 5'd0, 8'h00, 1'b0},
        // A value after a read is ignored.
        '{ACT_VALUE, KIND_READ_BITS, 8'h00, 8'h00, 24'h000000, 11'd0, 16'h0001,
          1'b1, 5'd0, 8'h00, 1'b0},
        // Bit write of an odd count: held bit, pair byte, lone last byte.
        '{ACT_HEADER, KIND_WRITE_BITS, LETTER_D, 8'hA8, 24'h000064, 11'd3, 16'h0000,
          1'b1, 5'd21, 8'h00, 1'b0},
        '{ACT_VALUE, KIND_WRITE_BITS, 8'hFF, 8'hFF, 24'hFFFFFF, 11'd2047, 16'hFFFF,
          1'b1, 5'd0, 8'h00, 1'b0},
        '{ACT_VALUE, KIND_WRITE_BITS, 8'h00, 8'h00, 24'h000000, 11'd0, 16'h0000,
          1'b1, 5'd1, 8'h10, 1'b0},
        '{ACT_VALUE, KIND_WRITE_BITS, 8'h00, 8'h00, 24'h000000, 11'd0, 16'h0001,
          1'b1, 5'd1, 8'h10, 1'b1},
        // A value after the frame is complete is ignored.
        '{ACT_VALUE, KIND_WRITE_BITS, 8'h00, 8'h00, 24'h000000, 11'd0, 16'h0001,
          1'b1, 5'd0, 8'h00, 1'b0},
        // Word write of two values.
        '{ACT_HEADER, KIND_WRITE_WORDS, LETTER_D, 8'hA8, 24'h000200, 11'd2, 16'h0000,
          1'b0, 5'd0, 8'h00, 1'b0},
        '{ACT_VALUE, KIND_WRITE_WORDS, 8'h00, 8'h00, 24'h000000, 11'd0, 16'hFFFF,
          1'b1, 5'd2, 8'hFF, 1'b0},
        '{ACT_VALUE, KIND_WRITE_WORDS, 8'h00, 8'h00, 24'h000000, 11'd0, 16'h0000,
          1'b1, 5'd2, 8'h00, 1'b1},
        // Empty writes close on the header.
        '{ACT_HEADER, KIND_WRITE_BITS, LETTER_M, 8'h90, 24'h000000, 11'd0, 16'h0000,
          1'b1, 5'd21, 8'h00, 1'b1},
        '{ACT_HEADER, KIND_WRITE_WORDS, LETTER_D, 8'hA8, 24'h000000, 11'd0, 16'h0000,
          1'b1, 5'd21, 8'h00, 1'b1},
        // Saturated bit write, one held bit, then abandoned by a new header.
        '{ACT_HEADER, KIND_WRITE_BITS, LETTER_Y, 8'h9D, 24'hFFFFFF, 11'd2047, 16'h0000,
          1'b1, 5'd21, 8'h04, 1'b0},
        '{ACT_VALUE, KIND_WRITE_BITS, 8'h00, 8'h00, 24'h000000, 11'd0, 16'h0001,
          1'b1, 5'd0, 8'h00, 1'b0},
        '{ACT_HEADER, KIND_READ_WORDS, LETTER_D, 8'hA8, 24'hABCDEF, 11'd5, 16'hFFFF,
          1'b0, 5'd0, 8'h00, 1'b0},
        // Single bit write: the lone point lands at bit 4.
        '{ACT_HEADER, KIND_WRITE_BITS, LETTER_M, 8'h90, 24'h000007, 11'd1, 16'h0000,
          1'b0, 5'd0, 8'h00, 1'b0},
        '{ACT_VALUE, KIND_WRITE_BITS, 8'h00, 8'h00, 24'h000000, 11'd0, 16'h0001,
          1'b1, 5'd1, 8'h10, 1'b1},
        // Single word write.
        '{ACT_HEADER, KIND_WRITE_WORDS, LETTER_D, 8'hA8, 24'h000300, 11'd1, 16'h0000,
          1'b0, 5'd0, 8'h00, 1'b0},
        '{ACT_VALUE, KIND_WRITE_WORDS, 8'h00, 8'h00, 24'h000000, 11'd0, 16'h8001,
          1'b1, 5'd2, 8'h80, 1'b1}
    };

    mc3e_request_frame_builder dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    // Clock generation.
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Run limit.
    initial begin
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT) begin
                $display("Timeout after %0d cycles", cycle_count);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // Prints one mismatch line and counts it.
    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= PRINT_LIMIT) begin
            $display("ERROR at %0t ns: %s", $time, msg);
        end
    endtask

    // Adds one byte to the expected stream.
    task automatic expect_byte(input logic [7:0] data, input logic last);
        t_frame_byte b;
        b.data = data;
        b.last = last;
        pending_bytes.push_back(b);
        made_n++;
        made_tail = b;
    endtask

    // Frame predictor: works out the bytes caused by one accepted item.
    // Sets taken low for a value item that the block ignores.
    task automatic predict_frame(input t_req_item it, output bit taken);
        logic [10:0] n;
        logic [15:0] cmd;
        logic [15:0] sub;
        logic [15:0] cnt;
        logic [15:0] len;
        logic        close;
        int          payload;
        made_n = 0;
        taken = 1'b1;
        if (it.action == ACT_HEADER) begin
            n = (it.count > MAX_POINTS) ? MAX_POINTS : it.count;
            cmd = it.kind[0] ? CMD_WRITE : CMD_READ;
            sub = (it.kind == KIND_READ_WORDS || it.kind == KIND_WRITE_WORDS) ?
                  SUB_WORD : SUB_BIT;
            cnt = 16'(n);
            if (it.kind == KIND_READ_BITS && n > 11'd8 &&
                it.letter inside {LETTER_X, LETTER_Y, LETTER_M}) begin
                sub = SUB_WORD;
                cnt = 16'((int'(n) + 15) / 16);
            end
            payload = 10;
            if (it.kind == KIND_WRITE_BITS) begin
                payload += (int'(n) + 1) / 2;
            end else if (it.kind == KIND_WRITE_WORDS) begin
                payload += 2 * int'(n);
            end
            len = 16'(2 + payload);
            open_kind = it.kind;
            values_due = (it.kind == KIND_WRITE_BITS || it.kind == KIND_WRITE_WORDS) ?
                         n : 11'd0;
            held_pt = 1'b0;
            pair_open = 1'b0;
            close = (values_due == 11'd0);
            expect_byte(cfg_model.sub_header[15:8], 1'b0);
            expect_byte(cfg_model.sub_header[7:0], 1'b0);
            expect_byte(cfg_model.network_number, 1'b0);
            expect_byte(cfg_model.pc_number, 1'b0);
            expect_byte(cfg_model.dest_module_io[7:0], 1'b0);
            expect_byte(cfg_model.dest_module_io[15:8], 1'b0);
            expect_byte(cfg_model.station_number, 1'b0);
            expect_byte(len[7:0], 1'b0);
            expect_byte(len[15:8], 1'b0);
            expect_byte(cfg_model.monitor_time[7:0], 1'b0);
            expect_byte(cfg_model.monitor_time[15:8], 1'b0);
            expect_byte(cmd[7:0], 1'b0);
            expect_byte(cmd[15:8], 1'b0);
            expect_byte(sub[7:0], 1'b0);
            expect_byte(sub[15:8], 1'b0);
            expect_byte(it.addr[7:0], 1'b0);
            expect_byte(it.addr[15:8], 1'b0);
            expect_byte(it.addr[23:16], 1'b0);
            expect_byte(it.code, 1'b0);
            expect_byte(cnt[7:0], 1'b0);
            expect_byte(cnt[15:8], close);
        end else if (values_due == 11'd0) begin
            taken = 1'b0;
        end else begin
            values_due = values_due - 11'd1;
            if (open_kind == KIND_WRITE_WORDS) begin
                expect_byte(it.value[7:0], 1'b0);
                expect_byte(it.value[15:8], values_due == 11'd0);
            end else if (open_kind != KIND_WRITE_BITS) begin
                values_due = 11'd0;
            end else if (pair_open) begin
                // Second bit of a pair completes the byte.
                pair_open = 1'b0;
                expect_byte({3'b000, held_pt, 3'b000, it.value[0]}, values_due == 11'd0);
                held_pt = 1'b0;
            end else if (values_due == 11'd0) begin
                // Odd count: the last point goes out alone.
                expect_byte({3'b000, it.value[0], 4'b0000}, 1'b1);
            end else begin
                held_pt = it.value[0];
                pair_open = 1'b1;
            end
        end
    endtask

    // Offers one item, waits for its transfer and predicts its bytes.
    task automatic send_item(input t_req_item it);
        bit taken;
        while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {5'b00000, it.value, it.count, it.addr, it.code, it.letter};
        i_s_axis_tuser  <= {it.kind, it.action};
        do begin
            @(posedge i_clk);
        end while (!o_s_axis_tready);
        predict_frame(it, taken);
        if (taken) begin
            items_taken++;
        end
    endtask

    // Stops offering items and waits until every expected byte has come out,
    // then lets the block finish any item that makes no byte.
    task automatic wait_drained();
        i_s_axis_tvalid <= 1'b0;
        while (pending_bytes.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // One register write; the enable stays up for back-to-back writes.
    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
    endtask

    // Writes the whole register set.
    task automatic load_regs(input t_cfg c);
        put_reg(REG_SUB_HEADER, c.sub_header);
        put_reg(REG_NETWORK_NUMBER, 16'(c.network_number));
        put_reg(REG_PC_NUMBER, 16'(c.pc_number));
        put_reg(REG_DEST_MODULE_IO, c.dest_module_io);
        put_reg(REG_STATION_NUMBER, 16'(c.station_number));
        put_reg(REG_MONITOR_TIME, c.monitor_time);
        i_cfg_wr_en <= 1'b0;
        cfg_model = c;
    endtask

    task automatic set_pace(input t_pace p);
        case (p)
            PACE_NONE: begin
                src_idle_pct = 0;
                sink_stall_pct = 0;
            end
            PACE_SRC: begin
                src_idle_pct = 76;
                sink_stall_pct = 0;
            end
            PACE_SINK: begin
                src_idle_pct = 0;
                sink_stall_pct = 76;
            end
            default: begin
                src_idle_pct = 26;
                sink_stall_pct = 26;
            end
        endcase
    endtask

    // Random request sequences until the phase has taken enough items.
    task automatic run_requests(input int target);
        t_req_item it;
        int        r;
        int        nv;
        int        nsend;
        target += items_taken;
        while (items_taken < target) begin
            it.action = ACT_HEADER;
            it.kind   = 2'($urandom_range(3));
            it.code   = 8'($urandom);
            it.addr   = 24'($urandom);
            it.value  = 16'($urandom);
            case ($urandom_range(5))
                0: it.letter = LETTER_X;
                1: it.letter = LETTER_Y;
                2: it.letter = LETTER_M;
                3: it.letter = LETTER_LOWER_X;
                default: it.letter = 8'($urandom);
            endcase
            r = $urandom_range(99);
            if (r < 80) begin
                it.count = 11'($urandom_range(12));
            end else if (r < 94) begin
                it.count = 11'($urandom_range(40, 13));
            end else begin
                it.count = 11'($urandom_range(2047));
            end
            if ($urandom_range(99) < 10) begin
                // Stray value with random content.
                it.action = ACT_VALUE;
                it.count = 11'($urandom);
                send_item(it);
            end else begin
                send_item(it);
                nv = (it.count > MAX_POINTS) ? int'(MAX_POINTS) : int'(it.count);
                if (it.kind == KIND_WRITE_BITS || it.kind == KIND_WRITE_WORDS) begin
                    nsend = nv;
                    if (nv > 40) begin
                        nsend = $urandom_range(10);
                    end else if (nv > 0 && $urandom_range(99) < 10) begin
                        nsend = $urandom_range(nv - 1);
                    end
                    if (nsend == nv && $urandom_range(99) < 15) begin
                        nsend++;
                    end
                    for (int v = 0; v < nsend; v++) begin
                        it.action = ACT_VALUE;
                        it.value  = 16'($urandom);
                        it.letter = 8'($urandom);
                        it.code   = 8'($urandom);
                        it.addr   = 24'($urandom);
                        it.count  = 11'($urandom);
                        it.kind   = 2'($urandom);
                        send_item(it);
                    end
                end
            end
        end
    endtask

    // Output side: checks each byte transfer and paces tready.
    initial begin
        t_frame_byte want;
        int          stall_left;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
                if (pending_bytes.size() == 0) begin
                    report_mismatch($sformatf("unexpected byte %02h last %0b",
                                              o_m_axis_tdata, o_m_axis_tlast));
                end else begin
                    want = pending_bytes.pop_front();
                    if (o_m_axis_tdata !== want.data) begin
                        report_mismatch($sformatf("out_byte %02h, expected %02h",
                                                  o_m_axis_tdata, want.data));
                    end
                    if (o_m_axis_tlast !== want.last) begin
                        report_mismatch($sformatf("frame_last %0b, expected %0b (byte %02h)",
                                                  o_m_axis_tlast, want.last, want.data));
                    end
                end
            end
            if (stall_left != 0) begin
                stall_left--;
                i_m_axis_tready <= 1'b0;
            end else if (hold_request) begin
                // Long hold-off so that the job queue fills and input stalls.
                hold_request = 1'b0;
                stall_left = HOLD_CYCLES;
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= !(sink_stall_pct != 0 &&
                                     $urandom_range(99) < sink_stall_pct);
            end
        end
    end

    // Main sequence.
    initial begin
        t_req_item it;
        t_cfg      c;
        t_pace     pace_list [0:5];
        pace_list = '{PACE_NONE, PACE_SRC, PACE_SINK, PACE_BOTH, PACE_SRC, PACE_BOTH};
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed pass at the reset register values.
        set_pace(PACE_NONE);
        for (int i = 0; i < DIR_ROWS; i++) begin
            it.action = directed_rows[i].action;
            it.kind   = directed_rows[i].kind;
            it.letter = directed_rows[i].letter;
            it.code   = directed_rows[i].code;
            it.addr   = directed_rows[i].addr;
            it.count  = directed_rows[i].count;
            it.value  = directed_rows[i].value;
            send_item(it);
            if (directed_rows[i].chk) begin
                if (made_n != int'(directed_rows[i].exp_n)) begin
                    report_mismatch($sformatf("row %0d makes %0d bytes, expected %0d",
                                              i, made_n, directed_rows[i].exp_n));
                end else if (made_n != 0 &&
                             (made_tail.data !== directed_rows[i].exp_tail ||
                              made_tail.last !== directed_rows[i].exp_last)) begin
                    report_mismatch($sformatf("row %0d ends %02h/%0b, expected %02h/%0b",
                                              i, made_tail.data, made_tail.last,
                                              directed_rows[i].exp_tail,
                                              directed_rows[i].exp_last));
                end
            end
        end

        // Random phases, each loading a register set and a pacing before it runs.
        for (int ph = 0; ph < 6; ph++) begin
            wait_drained();
            case (ph)
                0: c = '0;
                1: c = '1;
                4: c = CFG_RESET;
                default: begin
                    c.sub_header     = 16'($urandom);
                    c.network_number = 8'($urandom);
                    c.pc_number      = 8'($urandom);
                    c.dest_module_io = 16'($urandom);
                    c.station_number = 8'($urandom);
                    c.monitor_time   = 16'($urandom);
                end
            endcase
            load_regs(c);
            set_pace(pace_list[ph]);
            if (pace_list[ph] == PACE_SINK) begin
                hold_request = 1'b1;
            end
            run_requests(PHASE_ITEMS);
        end

        wait_drained();
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

@@ mc3e_request_frame_builder.f @@
design/mc3e_pkg.sv
design/mc3e_front.sv
design/mc3e_queue.sv
design/mc3e_back.sv
design/mc3e_request_frame_builder.sv
tb/mc3e_request_frame_builder_tb.sv
